// ===== sv/mpurb_pkg.sv =====
// Shared constants, types and pointer helpers for the multiport UART ring buffers.
package mpurb_pkg;

  // Block sizing.
  localparam int PORT_COUNT       = 9;
  localparam int RX_RING_SIZE     = 1024;
  localparam int TX_RING_SIZE     = 1024;
  localparam int HW_TX_FIFO_DEPTH = 64;
  localparam int CMDQ_DEPTH       = 2;

  // Fixed field widths of the beats.
  localparam int OP_W    = 2;
  localparam int PORT_W  = 4;
  localparam int DATA_W  = 8;
  localparam int USED_W  = 7;
  localparam int COUNT_W = 10;

  // Derived widths.
  localparam int PORT_IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int RX_PTR_W   = $clog2(RX_RING_SIZE);
  localparam int TX_PTR_W   = $clog2(TX_RING_SIZE);
  localparam int DRAIN_W    = $clog2(HW_TX_FIFO_DEPTH + 1);
  localparam int RX_DEPTH   = PORT_COUNT * RX_RING_SIZE;
  localparam int TX_DEPTH   = PORT_COUNT * TX_RING_SIZE;
  localparam int RX_ADDR_W  = $clog2(RX_DEPTH);
  localparam int TX_ADDR_W  = $clog2(TX_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_RX_PUT = 2'd0,
    OP_RX_GET = 2'd1,
    OP_TX_PUT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_RX_WRITE = 2'd0,
    CMD_RX_READ  = 2'd1,
    CMD_TX_WRITE = 2'd2,
    CMD_STATUS   = 2'd3
  } cmd_kind_e;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_RX   = 2'd1,
    SRC_TX   = 2'd2
  } byte_src_e;

  // One classified command handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_e               kind;
    logic [PORT_IDX_W-1:0]   port;
    logic [RX_PTR_W-1:0]     rx_ptr;
    logic [TX_PTR_W-1:0]     tx_wr_ptr;
    logic [TX_PTR_W-1:0]     tx_rd_ptr;
    logic [DATA_W-1:0]       data;
    logic [DRAIN_W-1:0]      drain_n;
    logic [COUNT_W-1:0]      rx_count;
    logic [COUNT_W-1:0]      tx_count;
  } cmd_t;

  function automatic logic [RX_PTR_W-1:0] rx_ptr_inc(input logic [RX_PTR_W-1:0] p);
    logic [RX_PTR_W-1:0] r;
    if (p == RX_PTR_W'(RX_RING_SIZE - 1)) begin
      r = '0;
    end else begin
      r = p + RX_PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [TX_PTR_W-1:0] tx_ptr_inc(input logic [TX_PTR_W-1:0] p);
    logic [TX_PTR_W-1:0] r;
    if (p == TX_PTR_W'(TX_RING_SIZE - 1)) begin
      r = '0;
    end else begin
      r = p + TX_PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== sv/mpurb_ram.sv =====
// Generic single-port RAM with registered read data.
module mpurb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mpurb_front.sv =====
// Front end: accepts beats, keeps the ring pointers and classifies each beat into a command.
module mpurb_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [mpurb_pkg::OP_W-1:0]        op_i,
  input  logic [mpurb_pkg::PORT_W-1:0]      port_i,
  input  logic [mpurb_pkg::DATA_W-1:0]      data_i,
  input  logic                              final_byte_i,
  input  logic [mpurb_pkg::USED_W-1:0]      fifo_used_i,
  output logic                              push_o,
  output mpurb_pkg::cmd_t                   cmd_o
);

  localparam int RXW = mpurb_pkg::RX_PTR_W;
  localparam int TXW = mpurb_pkg::TX_PTR_W;
  localparam int DW  = mpurb_pkg::DRAIN_W;
  localparam int CW  = TXW + DW;

  logic [RXW-1:0] rx_head_q [mpurb_pkg::PORT_COUNT];
  logic [RXW-1:0] rx_tail_q [mpurb_pkg::PORT_COUNT];
  logic [TXW-1:0] tx_head_q [mpurb_pkg::PORT_COUNT];
  logic [TXW-1:0] tx_tail_q [mpurb_pkg::PORT_COUNT];

  logic [mpurb_pkg::PORT_IDX_W-1:0] idx;
  logic                             port_ok;
  logic                             acc;
  logic [RXW-1:0] rx_h, rx_t, rx_h_d, rx_t_d;
  logic [TXW-1:0] tx_h, tx_t, tx_h_d, tx_t_d;
  logic [TXW-1:0] tx_len_pre;
  logic [DW-1:0]  room;
  logic [DW-1:0]  drain_n;
  logic [TXW:0]   tail_sum;

  function automatic logic [RXW-1:0] rx_len(input logic [RXW-1:0] h, input logic [RXW-1:0] t);
    logic [RXW:0] d;
    d = {1'b0, h} - {1'b0, t};
    if (h < t) begin
      d = d + (RXW+1)'(mpurb_pkg::RX_RING_SIZE);
    end
    return d[RXW-1:0];
  endfunction

  function automatic logic [TXW-1:0] tx_len(input logic [TXW-1:0] h, input logic [TXW-1:0] t);
    logic [TXW:0] d;
    d = {1'b0, h} - {1'b0, t};
    if (h < t) begin
      d = d + (TXW+1)'(mpurb_pkg::TX_RING_SIZE);
    end
    return d[TXW-1:0];
  endfunction

  assign acc    = start_i & ~busy_i;
  assign push_o = acc;

  always_comb begin
    idx     = port_i[mpurb_pkg::PORT_IDX_W-1:0];
    port_ok = ({1'b0, port_i} < (mpurb_pkg::PORT_W+1)'(mpurb_pkg::PORT_COUNT));
    rx_h    = rx_head_q[idx];
    rx_t    = rx_tail_q[idx];
    tx_h    = tx_head_q[idx];
    tx_t    = tx_tail_q[idx];
    rx_h_d  = rx_h;
    rx_t_d  = rx_t;
    tx_h_d  = tx_h;
    tx_t_d  = tx_t;

    // Drain sizing for a final user byte: min(ring length, free FIFO space).
    tx_len_pre = tx_len(mpurb_pkg::tx_ptr_inc(tx_h), tx_t);
    if (fifo_used_i >= mpurb_pkg::USED_W'(mpurb_pkg::HW_TX_FIFO_DEPTH)) begin
      room = '0;
    end else begin
      room = DW'(mpurb_pkg::HW_TX_FIFO_DEPTH) - DW'(fifo_used_i);
    end
    if (CW'(tx_len_pre) < CW'(room)) begin
      drain_n = DW'(tx_len_pre);
    end else begin
      drain_n = room;
    end
    if (!final_byte_i) begin
      drain_n = '0;
    end
    tail_sum = (TXW+1)'(tx_t) + (TXW+1)'(drain_n);
    if (tail_sum >= (TXW+1)'(mpurb_pkg::TX_RING_SIZE)) begin
      tail_sum = tail_sum - (TXW+1)'(mpurb_pkg::TX_RING_SIZE);
    end

    cmd_o           = '0;
    cmd_o.kind      = mpurb_pkg::CMD_STATUS;
    cmd_o.port      = idx;
    cmd_o.data      = data_i;
    cmd_o.tx_wr_ptr = tx_h;
    cmd_o.tx_rd_ptr = tx_t;

    case (mpurb_pkg::op_e'(op_i))
      mpurb_pkg::OP_RX_PUT: begin
        cmd_o.kind   = mpurb_pkg::CMD_RX_WRITE;
        cmd_o.rx_ptr = rx_h;
        rx_h_d       = mpurb_pkg::rx_ptr_inc(rx_h);
      end
      mpurb_pkg::OP_RX_GET: begin
        if (rx_h != rx_t) begin
          cmd_o.kind   = mpurb_pkg::CMD_RX_READ;
          cmd_o.rx_ptr = rx_t;
          rx_t_d       = mpurb_pkg::rx_ptr_inc(rx_t);
        end
      end
      mpurb_pkg::OP_TX_PUT: begin
        cmd_o.kind    = mpurb_pkg::CMD_TX_WRITE;
        cmd_o.drain_n = drain_n;
        tx_h_d        = mpurb_pkg::tx_ptr_inc(tx_h);
        tx_t_d        = tail_sum[TXW-1:0];
      end
      mpurb_pkg::OP_CLEAR: begin
        rx_h_d = '0;
        rx_t_d = '0;
        tx_h_d = '0;
        tx_t_d = '0;
      end
      default: begin
        cmd_o.kind = mpurb_pkg::CMD_STATUS;
      end
    endcase

    cmd_o.rx_count = mpurb_pkg::COUNT_W'(rx_len(rx_h_d, rx_t_d));
    cmd_o.tx_count = mpurb_pkg::COUNT_W'(tx_len(tx_h_d, tx_t_d));

    // A port beyond the last one touches nothing and reports zeros.
    if (!port_ok) begin
      cmd_o.kind     = mpurb_pkg::CMD_STATUS;
      cmd_o.rx_count = '0;
      cmd_o.tx_count = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mpurb_pkg::PORT_COUNT; i++) begin
        rx_head_q[i] <= '0;
        rx_tail_q[i] <= '0;
        tx_head_q[i] <= '0;
        tx_tail_q[i] <= '0;
      end
    end else if (acc && port_ok) begin
      rx_head_q[idx] <= rx_h_d;
      rx_tail_q[idx] <= rx_t_d;
      tx_head_q[idx] <= tx_h_d;
      tx_tail_q[idx] <= tx_t_d;
    end
  end

endmodule

// ===== sv/mpurb_cmdq.sv =====
// Short command queue between the front end and the back end.
module mpurb_cmdq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mpurb_pkg::cmd_t cmd_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output mpurb_pkg::cmd_t cmd_o
);

  localparam int IDX_W = (mpurb_pkg::CMDQ_DEPTH > 1) ? $clog2(mpurb_pkg::CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(mpurb_pkg::CMDQ_DEPTH + 1);

  mpurb_pkg::cmd_t   slot_q [mpurb_pkg::CMDQ_DEPTH];
  logic [IDX_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IDX_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    if (p == IDX_W'(mpurb_pkg::CMDQ_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + IDX_W'(1);
    end
    return r;
  endfunction

  assign full_o  = (cnt_q == CNT_W'(mpurb_pkg::CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? idx_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? idx_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/mpurb_back.sv =====
// Back end: executes commands in order on the two byte stores and issues the result beats.
module mpurb_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  mpurb_pkg::cmd_t                   cmd_i,
  output logic                              pop_o,
  output logic                              strobe_o,
  output logic [mpurb_pkg::DATA_W-1:0]      byte_out_o,
  output logic                              byte_valid_o,
  output logic                              to_uart_o,
  output logic [mpurb_pkg::COUNT_W-1:0]     rx_count_o,
  output logic [mpurb_pkg::COUNT_W-1:0]     tx_count_o,
  output logic                              last_o
);

  localparam int RAW = mpurb_pkg::RX_ADDR_W;
  localparam int TAW = mpurb_pkg::TX_ADDR_W;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } back_state_e;

  back_state_e                          state_q, state_d;
  logic [mpurb_pkg::DRAIN_W-1:0]        dr_cnt_q, dr_cnt_d;
  logic [mpurb_pkg::TX_PTR_W-1:0]       dr_ptr_q, dr_ptr_d;
  logic [mpurb_pkg::PORT_IDX_W-1:0]     dr_port_q, dr_port_d;
  logic [mpurb_pkg::COUNT_W-1:0]        dr_rxc_q, dr_rxc_d;
  logic [mpurb_pkg::COUNT_W-1:0]        dr_txc_q, dr_txc_d;

  logic                                 res_valid_q, res_valid_d;
  mpurb_pkg::byte_src_e                 res_src_q, res_src_d;
  logic [mpurb_pkg::COUNT_W-1:0]        res_rxc_q, res_rxc_d;
  logic [mpurb_pkg::COUNT_W-1:0]        res_txc_q, res_txc_d;
  logic                                 res_last_q, res_last_d;

  logic                                 rx_en, rx_we;
  logic [RAW-1:0]                       rx_addr;
  logic [mpurb_pkg::DATA_W-1:0]         rx_rdata;
  logic                                 tx_en, tx_we;
  logic [TAW-1:0]                       tx_addr;
  logic [mpurb_pkg::DATA_W-1:0]         tx_rdata;

  function automatic logic [RAW-1:0] rx_addr_of(input logic [mpurb_pkg::PORT_IDX_W-1:0] p,
                                                input logic [mpurb_pkg::RX_PTR_W-1:0] ptr);
    return RAW'(p) * RAW'(mpurb_pkg::RX_RING_SIZE) + RAW'(ptr);
  endfunction

  function automatic logic [TAW-1:0] tx_addr_of(input logic [mpurb_pkg::PORT_IDX_W-1:0] p,
                                                input logic [mpurb_pkg::TX_PTR_W-1:0] ptr);
    return TAW'(p) * TAW'(mpurb_pkg::TX_RING_SIZE) + TAW'(ptr);
  endfunction

  assign pop_o = (state_q == ST_RUN) && cmd_valid_i;

  always_comb begin
    state_d     = state_q;
    dr_cnt_d    = dr_cnt_q;
    dr_ptr_d    = dr_ptr_q;
    dr_port_d   = dr_port_q;
    dr_rxc_d    = dr_rxc_q;
    dr_txc_d    = dr_txc_q;
    res_valid_d = 1'b0;
    res_src_d   = mpurb_pkg::SRC_NONE;
    res_rxc_d   = cmd_i.rx_count;
    res_txc_d   = cmd_i.tx_count;
    res_last_d  = 1'b1;
    rx_en       = 1'b0;
    rx_we       = 1'b0;
    rx_addr     = rx_addr_of(cmd_i.port, cmd_i.rx_ptr);
    tx_en       = 1'b0;
    tx_we       = 1'b0;
    tx_addr     = tx_addr_of(cmd_i.port, cmd_i.tx_wr_ptr);

    case (state_q)
      ST_RUN: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            mpurb_pkg::CMD_RX_WRITE: begin
              rx_en       = 1'b1;
              rx_we       = 1'b1;
              res_valid_d = 1'b1;
            end
            mpurb_pkg::CMD_RX_READ: begin
              rx_en       = 1'b1;
              res_valid_d = 1'b1;
              res_src_d   = mpurb_pkg::SRC_RX;
            end
            mpurb_pkg::CMD_TX_WRITE: begin
              tx_en = 1'b1;
              tx_we = 1'b1;
              if (cmd_i.drain_n == '0) begin
                res_valid_d = 1'b1;
              end else begin
                state_d   = ST_DRAIN;
                dr_cnt_d  = cmd_i.drain_n;
                dr_ptr_d  = cmd_i.tx_rd_ptr;
                dr_port_d = cmd_i.port;
                dr_rxc_d  = cmd_i.rx_count;
                dr_txc_d  = cmd_i.tx_count;
              end
            end
            mpurb_pkg::CMD_STATUS: begin
              res_valid_d = 1'b1;
            end
            default: begin
              res_valid_d = 1'b0;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        tx_en       = 1'b1;
        tx_addr     = tx_addr_of(dr_port_q, dr_ptr_q);
        res_valid_d = 1'b1;
        res_src_d   = mpurb_pkg::SRC_TX;
        res_rxc_d   = dr_rxc_q;
        res_txc_d   = dr_txc_q;
        res_last_d  = (dr_cnt_q == mpurb_pkg::DRAIN_W'(1));
        dr_ptr_d    = mpurb_pkg::tx_ptr_inc(dr_ptr_q);
        dr_cnt_d    = dr_cnt_q - mpurb_pkg::DRAIN_W'(1);
        if (dr_cnt_q == mpurb_pkg::DRAIN_W'(1)) begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      dr_cnt_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dr_cnt_q    <= dr_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_ptr_q   <= dr_ptr_d;
    dr_port_q  <= dr_port_d;
    dr_rxc_q   <= dr_rxc_d;
    dr_txc_q   <= dr_txc_d;
    res_src_q  <= res_src_d;
    res_rxc_q  <= res_rxc_d;
    res_txc_q  <= res_txc_d;
    res_last_q <= res_last_d;
  end

  mpurb_ram #(
    .WIDTH (mpurb_pkg::DATA_W),
    .DEPTH (mpurb_pkg::RX_DEPTH)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .en_i    (rx_en),
    .we_i    (rx_we),
    .addr_i  (rx_addr),
    .wdata_i (cmd_i.data),
    .rdata_o (rx_rdata)
  );

  mpurb_ram #(
    .WIDTH (mpurb_pkg::DATA_W),
    .DEPTH (mpurb_pkg::TX_DEPTH)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .en_i    (tx_en),
    .we_i    (tx_we),
    .addr_i  (tx_addr),
    .wdata_i (cmd_i.data),
    .rdata_o (tx_rdata)
  );

  always_comb begin
    case (res_src_q)
      mpurb_pkg::SRC_RX: byte_out_o = rx_rdata;
      mpurb_pkg::SRC_TX: byte_out_o = tx_rdata;
      default:           byte_out_o = '0;
    endcase
  end

  assign strobe_o     = res_valid_q;
  assign byte_valid_o = (res_src_q != mpurb_pkg::SRC_NONE);
  assign to_uart_o    = (res_src_q == mpurb_pkg::SRC_TX);
  assign rx_count_o   = res_rxc_q;
  assign tx_count_o   = res_txc_q;
  assign last_o       = res_last_q;

endmodule

// ===== sv/multiport_uart_ring_buffers.sv =====
// Top level of the multiport UART receive and transmit byte rings.
//
// Usage: an input beat (op, port, data, final_byte, fifo_used) is taken at a rising
// edge where start is high and busy is low. Op 0 stores a received byte, op 1 pops a
// byte for the user, op 2 pushes a user byte and, with final_byte set, drains as many
// transmit bytes as the ring holds and the hardware FIFO has room for, and op 3 clears
// a port's pointers. Result beats appear on the result ports for exactly one cycle
// each, marked by strobe_o; there is no back-pressure, so the receiver must take every
// beat. Each beat passes the command queue and the back end's result registers. The
// front end takes one beat per cycle while busy is low and updates the ring pointers
// at once; a two-entry command queue feeds the back end, which serves one command per
// cycle through the single port of each byte RAM, except that a draining push holds it
// for one write, then one read per drained byte. Busy rises only while the queue is
// full. After reset all pointers are zero, the queue is empty and no beat is pending;
// the byte stores need no clearing, as no entry is read before it has been written.
module multiport_uart_ring_buffers (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [mpurb_pkg::OP_W-1:0]        op_i,
  input  logic [mpurb_pkg::PORT_W-1:0]      port_i,
  input  logic [mpurb_pkg::DATA_W-1:0]      data_i,
  input  logic                              final_byte_i,
  input  logic [mpurb_pkg::USED_W-1:0]      fifo_used_i,
  output logic                              strobe_o,
  output logic [mpurb_pkg::DATA_W-1:0]      byte_out_o,
  output logic                              byte_valid_o,
  output logic                              to_uart_o,
  output logic [mpurb_pkg::COUNT_W-1:0]     rx_count_o,
  output logic [mpurb_pkg::COUNT_W-1:0]     tx_count_o,
  output logic                              last_o
);

  logic            q_full;
  logic            push;
  mpurb_pkg::cmd_t push_cmd;
  logic            q_valid;
  mpurb_pkg::cmd_t q_cmd;
  logic            pop;

  // The block only stalls its sender when the command queue has no free slot.
  assign busy = q_full;

  mpurb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (q_full),
    .op_i         (op_i),
    .port_i       (port_i),
    .data_i       (data_i),
    .final_byte_i (final_byte_i),
    .fifo_used_i  (fifo_used_i),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  mpurb_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  mpurb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd),
    .pop_o        (pop),
    .strobe_o     (strobe_o),
    .byte_out_o   (byte_out_o),
    .byte_valid_o (byte_valid_o),
    .to_uart_o    (to_uart_o),
    .rx_count_o   (rx_count_o),
    .tx_count_o   (tx_count_o),
    .last_o       (last_o)
  );

endmodule
